FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the DNS name decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define DLND_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Checks that a consequent holds in the cycle after an antecedent.
`define DLND_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/dlnd_pkg.sv
// Shared types and constants of the DNS name decoder.
package dlnd_pkg;

  localparam int unsigned NameSizeDefault = 256;
  localparam int unsigned LimitW          = 9;
  localparam logic [LimitW-1:0] LimitReset = 9'd256;

  localparam logic [1:0] PhLen   = 2'd0;
  localparam logic [1:0] PhLabel = 2'd1;
  localparam logic [1:0] PhDrop  = 2'd2;

  localparam logic [7:0] CharDot  = 8'd46;
  localparam logic [7:0] CharTerm = 8'd0;

  localparam logic StatusOk       = 1'b0;
  localparam logic StatusOverflow = 1'b1;

  // One decoded result, with a flag telling whether the step made one.
  typedef struct packed {
    logic       valid;
    logic [7:0] out_char;
    logic       is_last;
    logic       status;
  } result_t;

endpackage

FILE: rtl/dns_label_name_decoder.sv
// An accepted word goes through the input register, then the result register.
// Throughput: one word per cycle unless the master stalls; the name state updates in one
// step between the registers. Stalls on the master side back up through the input register
// with no loss. Reset (rst_ni low, asynchronous) empties both registers, sets the name limit
// to 256, and puts the decoder at the start of a name expecting a length byte.
module dns_label_name_decoder #(
  parameter int unsigned NAME_SIZE = dlnd_pkg::NameSizeDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Name limit register write channel.
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [8:0] cfg_data_i,
  // Encoded name bytes.
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] in_byte
  input  logic       s_axis_tuser_i,  // [0] name_start
  // Decoded characters.
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,  // [7:0] out_char
  output logic       m_axis_tlast_o,  // is_last
  output logic       m_axis_tuser_o   // [0] status
);
  import dlnd_pkg::*;
  `include "assert_macros.svh"

  // Counters hold up to NAME_SIZE, the largest limit that can be in force.
  localparam int unsigned CntW = $clog2(NAME_SIZE + 1);
  localparam int unsigned CmpW = CntW + LimitW;

  // The name limit register; the value used is clamped to 2..NAME_SIZE.
  logic [LimitW-1:0] limit_q;
  logic [CntW-1:0]   limit_eff;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (CmpW'(limit_q) < CmpW'(2)) begin
      limit_eff = CntW'(2);
    end else if (CmpW'(limit_q) > CmpW'(NAME_SIZE)) begin
      limit_eff = CntW'(NAME_SIZE);
    end else begin
      limit_eff = CntW'(limit_q);
    end
  end

  // Input register. It accepts a new word whenever it is empty or its
  // current word moves on in the same cycle, so words can stream back to back
  // as long as the master side takes each finished result.
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_start_q;
  logic       out_can_load;
  logic       advance;

  assign advance         = in_valid_q && out_can_load;
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q  <= s_axis_tdata_i;
      in_start_q <= s_axis_tuser_i;
    end
  end

  // Per-name decoder state, updated each time a word leaves the input register.
  logic [1:0]      phase_q,       phase_d;
  logic [CntW-1:0] in_count_q,    in_count_d;
  logic [CntW-1:0] out_count_q,   out_count_d;
  logic [7:0]      label_left_q,  label_left_d;
  logic            first_label_q, first_label_d;
  result_t         step_result;

  dlnd_step #(
    .CntW (CntW)
  ) u_step (
    .in_byte_i     (in_byte_q),
    .name_start_i  (in_start_q),
    .limit_i       (limit_eff),
    .phase_i       (phase_q),
    .in_count_i    (in_count_q),
    .out_count_i   (out_count_q),
    .label_left_i  (label_left_q),
    .first_label_i (first_label_q),
    .phase_o       (phase_d),
    .in_count_o    (in_count_d),
    .out_count_o   (out_count_d),
    .label_left_o  (label_left_d),
    .first_label_o (first_label_d),
    .result_o      (step_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhLen;
      in_count_q    <= '0;
      out_count_q   <= '0;
      label_left_q  <= '0;
      first_label_q <= 1'b1;
    end else if (advance) begin
      phase_q       <= phase_d;
      in_count_q    <= in_count_d;
      out_count_q   <= out_count_d;
      label_left_q  <= label_left_d;
      first_label_q <= first_label_d;
    end
  end

  // Result register. A word that gives no result simply leaves it untouched.
  dlnd_out_reg u_out_reg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (advance),
    .result_i        (step_result),
    .m_axis_tready_i (m_axis_tready_i),
    .can_load_o      (out_can_load),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // An overflow result always leaves the decoder dropping bytes.
  `DLND_ASSERT_NEXT(a_overflow_drops, advance && step_result.valid && step_result.status, phase_q == PhDrop, "overflow did not enter drop phase")

  // The last byte of a label returns the decoder to expecting a length byte.
  `DLND_ASSERT_NEXT(a_label_end, advance && !in_start_q && phase_q == PhLabel && label_left_q == 8'd1, phase_q == PhLen, "label end did not return to length phase")

  // A held word in the input register stays put while the result side is blocked.
  `DLND_ASSERT_NEXT(a_input_hold, in_valid_q && !out_can_load, in_valid_q && $stable(in_byte_q) && $stable(in_start_q), "input register changed while stalled")

endmodule

FILE: rtl/dlnd_step.sv
// Next-state and result logic for one encoded name byte.
module dlnd_step #(
  parameter int unsigned CntW = 9
) (
  input  logic [7:0]      in_byte_i,
  input  logic            name_start_i,
  input  logic [CntW-1:0] limit_i,
  input  logic [1:0]      phase_i,
  input  logic [CntW-1:0] in_count_i,
  input  logic [CntW-1:0] out_count_i,
  input  logic [7:0]      label_left_i,
  input  logic            first_label_i,
  output logic [1:0]      phase_o,
  output logic [CntW-1:0] in_count_o,
  output logic [CntW-1:0] out_count_o,
  output logic [7:0]      label_left_o,
  output logic            first_label_o,
  output dlnd_pkg::result_t result_o
);
  import dlnd_pkg::*;

  localparam int unsigned SumW = CntW + 10;

  logic [1:0]      ph;
  logic [CntW-1:0] inc;
  logic [CntW-1:0] outc;
  logic [7:0]      left;
  logic            first;
  logic [CntW-1:0] in_next;
  logic [7:0]      left_next;
  logic [SumW-1:0] in_sum;
  logic [SumW-1:0] out_sum;
  logic [SumW-1:0] lim_w;

  always_comb begin
    // A name start drops whatever name was in progress.
    if (name_start_i) begin
      ph    = PhLen;
      inc   = '0;
      outc  = '0;
      left  = '0;
      first = 1'b1;
    end else begin
      ph    = phase_i;
      inc   = in_count_i;
      outc  = out_count_i;
      left  = label_left_i;
      first = first_label_i;
    end

    in_next   = inc + CntW'(1);
    left_next = (left != 8'd0) ? left - 8'd1 : 8'd0;
    lim_w     = SumW'(limit_i);
    in_sum    = SumW'(in_next) + SumW'(in_byte_i);
    out_sum   = SumW'(outc) + SumW'(in_byte_i) + SumW'(1);

    phase_o       = ph;
    in_count_o    = inc;
    out_count_o   = outc;
    label_left_o  = left;
    first_label_o = first;
    result_o      = '{valid: 1'b0, out_char: CharTerm, is_last: 1'b0, status: StatusOk};

    case (ph)
      PhLen: begin
        in_count_o = in_next;
        if (in_byte_i == 8'd0) begin
          // Closing zero length: terminator, then a fresh name.
          phase_o       = PhLen;
          in_count_o    = '0;
          out_count_o   = '0;
          label_left_o  = '0;
          first_label_o = 1'b1;
          result_o = '{valid: 1'b1, out_char: CharTerm, is_last: 1'b1, status: StatusOk};
        end else if ((in_sum > lim_w) || (out_sum > lim_w)) begin
          phase_o  = PhDrop;
          result_o = '{valid: 1'b1, out_char: CharTerm, is_last: 1'b1,
                       status: StatusOverflow};
        end else begin
          label_left_o  = in_byte_i;
          out_count_o   = CntW'(out_sum);
          phase_o       = PhLabel;
          first_label_o = 1'b0;
          result_o = '{valid: !first, out_char: CharDot, is_last: 1'b0, status: StatusOk};
        end
      end
      PhLabel: begin
        in_count_o   = in_next;
        label_left_o = left_next;
        result_o = '{valid: 1'b1, out_char: in_byte_i, is_last: 1'b0, status: StatusOk};
        if (left_next == 8'd0) begin
          phase_o = PhLen;
          if (SumW'(in_next) >= lim_w) begin
            in_count_o       = '0;
            out_count_o      = '0;
            label_left_o     = '0;
            first_label_o    = 1'b1;
            result_o.is_last = 1'b1;
          end
        end
      end
      default: begin
        // Dropping, and the unused code, hold state and give no result.
      end
    endcase
  end

endmodule

FILE: rtl/dlnd_out_reg.sv
// Output result register driving the master stream side.
module dlnd_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  dlnd_pkg::result_t result_i,
  input  logic              m_axis_tready_i,
  output logic              can_load_o,
  output logic              m_axis_tvalid_o,
  output logic [7:0]        m_axis_tdata_o,
  output logic              m_axis_tlast_o,
  output logic              m_axis_tuser_o
);
  import dlnd_pkg::*;

  logic       valid_q;
  logic [7:0] char_q;
  logic       last_q;
  logic       status_q;

  assign can_load_o = !valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (can_load_o) begin
      valid_q <= load_i && result_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_load_o && load_i && result_i.valid) begin
      char_q   <= result_i.out_char;
      last_q   <= result_i.is_last;
      status_q <= result_i.status;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = char_q;
  assign m_axis_tlast_o  = last_q;
  assign m_axis_tuser_o  = status_q;

endmodule

FILE: tb/dlnd_decode_checker.sv
// Checker for the DNS name decoder: predicts decoded words and compares them.
`timescale 1ns / 100ps

module dlnd_decode_checker #(
  parameter int unsigned NAME_SIZE = dlnd_pkg::NameSizeDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [8:0]  cfg_data_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,
  input  logic        s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [7:0]  m_tdata_i,
  input  logic        m_tlast_i,
  input  logic        m_tuser_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o,
  output int unsigned words_checked_o,
  output int unsigned overflows_o
);

  import dlnd_pkg::*;

  logic [8:0] limit_value;
  logic [1:0] name_phase;
  logic [8:0] in_count;
  logic [8:0] out_count;
  logic [7:0] label_left;
  logic       first_label;

  result_t     expected_words[$];
  int unsigned mismatches;
  int unsigned words_checked;
  int unsigned overflows;

  function automatic void restart_name();
    name_phase  = PhLen;
    in_count    = '0;
    out_count   = '0;
    label_left  = '0;
    first_label = 1'b1;
  endfunction

  function automatic result_t make_word(logic [7:0] ch, logic last, logic st);
    result_t w;
    w.valid    = 1'b1;
    w.out_char = ch;
    w.is_last  = last;
    w.status   = st;
    return w;
  endfunction

  // Advances the name state by one input byte; valid is low when the byte makes no word.
  function automatic result_t decode_byte(logic [7:0] b, logic start);
    result_t w;
    int      lim;
    w   = '0;
    lim = (int'(limit_value) < 2) ? 2 :
          ((int'(limit_value) > int'(NAME_SIZE)) ? int'(NAME_SIZE) : int'(limit_value));
    if (start) restart_name();
    case (name_phase)
      PhLen: begin
        in_count = in_count + 9'd1;
        if (b == 8'd0) begin
          restart_name();
          w = make_word(CharTerm, 1'b1, StatusOk);
        end else if (int'(in_count) + int'(b) > lim ||
                     int'(out_count) + int'(b) + 1 > lim) begin
          name_phase = PhDrop;
          w = make_word(CharTerm, 1'b1, StatusOverflow);
        end else begin
          label_left = b;
          out_count  = out_count + 9'(b) + 9'd1;
          name_phase = PhLabel;
          if (first_label) begin
            first_label = 1'b0;
          end else begin
            w = make_word(CharDot, 1'b0, StatusOk);
          end
        end
      end
      PhLabel: begin
        in_count = in_count + 9'd1;
        if (label_left != 8'd0) label_left = label_left - 8'd1;
        w = make_word(b, 1'b0, StatusOk);
        if (label_left == 8'd0) begin
          name_phase = PhLen;
          // Hitting the input limit right after a label closes the name on this character.
          if (int'(in_count) >= lim) begin
            restart_name();
            w.is_last = 1'b1;
          end
        end
      end
      default: begin
        // Dropping until the next name start.
      end
    endcase
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    result_t got;
    if (!rst_ni) begin
      restart_name();
      limit_value = LimitReset;
      expected_words.delete();
      mismatches      = 0;
      words_checked   = 0;
      overflows       = 0;
      mismatches_o    <= 0;
      pending_o       <= 0;
      words_checked_o <= 0;
      overflows_o     <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got = make_word(m_tdata_i, m_tlast_i, m_tuser_i);
        words_checked++;
        if (got.status == StatusOverflow) overflows++;
        if (expected_words.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word, char %0d last %0b status %0b",
                   $time, got.out_char, got.is_last, got.status);
        end else begin
          want = expected_words.pop_front();
          if (got.out_char != want.out_char) begin
            mismatches++;
            $display("%0t: out_char expected %0d, actual %0d",
                     $time, want.out_char, got.out_char);
          end
          if (got.is_last != want.is_last) begin
            mismatches++;
            $display("%0t: is_last expected %0b, actual %0b",
                     $time, want.is_last, got.is_last);
          end
          if (got.status != want.status) begin
            mismatches++;
            $display("%0t: status expected %0b, actual %0b",
                     $time, want.status, got.status);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) limit_value = cfg_data_i;
      if (s_tvalid_i && s_tready_i) begin
        want = decode_byte(s_tdata_i, s_tuser_i);
        if (want.valid) expected_words.push_back(want);
      end
      mismatches_o    <= mismatches;
      pending_o       <= expected_words.size();
      words_checked_o <= words_checked;
      overflows_o     <= overflows;
    end
  end

endmodule

FILE: tb/dns_label_name_decoder_test.sv
// Top of the DNS name decoder test: clock, reset, byte stimulus, output stalls and verdict.
`timescale 1ns / 100ps

module dns_label_name_decoder_test;

  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned DrainCycles = 6;     // two register stages plus margin
  localparam int unsigned ByteTarget  = 1750;

  logic       clk;
  logic       rst_n;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [8:0] cfg_data;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       s_tuser;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic       m_tuser;

  int unsigned mismatches;
  int unsigned results_pending;
  int unsigned words_checked;
  int unsigned overflows;

  int unsigned cycle_count = 0;
  int unsigned bytes_sent  = 0;
  int unsigned names_sent  = 0;
  int unsigned limit_writes = 0;
  bit          fast_mode    = 1'b0;   // both sides run without idling while set

  dns_label_name_decoder i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tuser_o  (m_tuser)
  );

  dlnd_decode_checker i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .s_tvalid_i      (s_tvalid),
    .s_tready_i      (s_tready),
    .s_tdata_i       (s_tdata),
    .s_tuser_i       (s_tuser),
    .m_tvalid_i      (m_tvalid),
    .m_tready_i      (m_tready),
    .m_tdata_i       (m_tdata),
    .m_tlast_i       (m_tlast),
    .m_tuser_i       (m_tuser),
    .mismatches_o    (mismatches),
    .pending_o       (results_pending),
    .words_checked_o (words_checked),
    .overflows_o     (overflows)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // A hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Output side: a random stall before each word, none in fast stretches.
  initial begin : output_stalls
    int unsigned stall;
    m_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = fast_mode ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Sends one word after a random gap; tvalid stays high so back-to-back words need no bubble.
  task automatic send_byte(input logic [7:0] b, input logic start);
    int unsigned gap;
    gap = fast_mode ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= start;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
  endtask

  // Holds the input until every predicted word has come out, then lets the pipeline settle,
  // since a length byte or a dropped byte may still be inside without any word owed.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_limit(input logic [8:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    limit_writes++;
  endtask

  // One random name: mostly well formed, some cut short, some that fit the limit exactly,
  // and some plain noise with random start flags.
  task automatic send_name(input int unsigned lim);
    logic [7:0]  name_bytes[$];
    int unsigned kind;
    int unsigned labels;
    int unsigned len;
    int unsigned len_cap;
    logic        start;
    kind = $urandom_range(0, 9);
    names_sent++;
    if (kind == 0) begin
      repeat ($urandom_range(1, 6)) begin
        send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      return;
    end
    len_cap = lim / 3;
    if (len_cap < 1) len_cap = 1;
    if (len_cap > 63) len_cap = 63;
    if (kind == 2 && lim <= 64) begin
      // A single label that uses the whole input budget ends on its last character.
      name_bytes.push_back(8'(lim - 1));
      repeat (lim - 1) name_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      labels = $urandom_range(1, 4);
      repeat (labels) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 255) : $urandom_range(1, len_cap);
        name_bytes.push_back(8'(len));
        repeat (len) name_bytes.push_back(8'($urandom_range(0, 255)));
      end
      name_bytes.push_back(8'd0);
      if (kind == 1) name_bytes = name_bytes[0:$urandom_range(0, name_bytes.size() - 2)];
    end
    // Now and then rely on the previous terminator instead of a start flag.
    start = ($urandom_range(0, 7) != 0);
    foreach (name_bytes[i]) send_byte(name_bytes[i], (i == 0) ? start : 1'b0);
  endtask

  initial begin : stimulus
    logic [8:0]  corner_limits[8];
    logic [8:0]  value;
    int unsigned lim;
    int unsigned phase_end;
    corner_limits = '{9'd0, 9'd1, 9'd2, 9'd3, 9'd255, 9'd256, 9'd257, 9'd511};
    rst_n     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset limit of 256 first.
    // Two labels with extreme characters: no word for the first length byte, then a dot.
    send_byte(8'd2, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'd1, 1'b0);
    send_byte("x", 1'b0);
    send_byte(8'd0, 1'b0);
    // Root name, a lone terminator.
    send_byte(8'd0, 1'b1);
    // A 255 byte label after another label overruns the limit; the next byte is dropped.
    send_byte(8'd1, 1'b1);
    send_byte("a", 1'b0);
    send_byte(8'd255, 1'b0);
    send_byte(8'd4, 1'b0);
    // A start flag in the middle of a label drops the old name.
    send_byte(8'd5, 1'b1);
    send_byte("a", 1'b0);
    send_byte(8'd0, 1'b1);
    // After a terminator the next byte opens a new name without a start flag.
    send_byte(8'd1, 1'b1);
    send_byte("k", 1'b0);
    send_byte(8'd0, 1'b0);
    send_byte(8'd0, 1'b0);
    // Limit lowered in the middle of a label: the label finishes and closes the name.
    send_byte(8'd2, 1'b1);
    send_byte("p", 1'b0);
    write_limit(9'd2);
    send_byte("q", 1'b0);
    send_byte(8'd1, 1'b0);
    send_byte("r", 1'b0);
    // Zero clamps up to the smallest limit.
    write_limit(9'd0);
    send_byte(8'd2, 1'b1);
    write_limit(9'd4);
    send_byte(8'd3, 1'b1);
    send_byte("a", 1'b0);
    send_byte("b", 1'b0);
    send_byte("c", 1'b0);
    write_limit(9'd511);
    send_byte(8'd0, 1'b1);

    // Random part: phases with their own limit, each entered with the decoder idle.
    while (bytes_sent < ByteTarget) begin
      case ($urandom_range(0, 5))
        0:       value = corner_limits[$urandom_range(0, 7)];
        1:       value = 9'($urandom_range(0, 511));
        default: value = 9'($urandom_range(2, 40));
      endcase
      write_limit(value);
      lim = (int'(value) < 2) ? 2 : ((int'(value) > 256) ? 256 : int'(value));
      fast_mode = ($urandom_range(0, 3) == 0);
      phase_end = bytes_sent + $urandom_range(80, 160);
      while (bytes_sent < phase_end) send_name(lim);
    end
    fast_mode = 1'b0;

    drain_results();
    $display("sent %0d bytes in %0d names under %0d limit settings",
             bytes_sent, names_sent, limit_writes);
    $display("checked %0d decoded words, %0d of them overflow reports",
             words_checked, overflows);
    if (mismatches == 0 && results_pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
